// ===== rtl/vector_tile_geometry_decoder_defines.svh =====
// Assertion macros for the vector tile geometry decoder.
// Included by the top level only; depends on nothing else.
`ifndef VECTOR_TILE_GEOMETRY_DECODER_DEFINES_SVH
`define VECTOR_TILE_GEOMETRY_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VTGD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vtgd check failed");

// Next-cycle implication, disabled while reset is asserted.
`define VTGD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vtgd check failed");

`endif

// ===== rtl/vtgd_pkg.sv =====
// Types, constants and helper functions for the vector tile geometry decoder.
// Used by the top level, the front end, the queue and the back end; depends on nothing.
package vtgd_pkg;

  localparam int COORD_BITS = 64;
  localparam int CoordShift = 64 - COORD_BITS;

  localparam int QDEPTH = 2;  // Must be a power of two.
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [6:0] MAX_SHIFT   = 7'd63;
  localparam logic [6:0] SHIFT_STEP  = 7'd7;
  localparam logic [2:0] CMD_MOVE    = 3'h1;
  localparam logic [2:0] CMD_LINE    = 3'h2;
  localparam logic [2:0] CMD_CLOSE   = 3'h7;

  typedef enum logic [2:0] {
    KIND_START  = 3'd0,
    KIND_EXTEND = 3'd1,
    KIND_CLOSE  = 3'd2,
    KIND_END    = 3'd3,
    KIND_ERROR  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_OVERSIZE = 2'd1,
    ERR_UNKNOWN  = 2'd2,
    ERR_TRUNC    = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    PH_CMD = 2'd0,
    PH_X   = 2'd1,
    PH_Y   = 2'd2
  } phase_t;

  // What the front end hands to the back end for each word it pushes.
  typedef enum logic [1:0] {
    TOK_WORD     = 2'd0,
    TOK_TRUNC    = 2'd1,
    TOK_OVERSIZE = 2'd2,
    TOK_LASTONLY = 2'd3
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [63:0] value;
    logic        last;
  } tok_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [63:0] unzigzag(input logic [63:0] v);
    return (v >> 1) ^ {64{v[0]}};
  endfunction

  // Wraps to COORD_BITS bits and sign extends back to 64 bits.
  function automatic logic [63:0] coord_wrap(input logic [63:0] v);
    logic signed [63:0] t;
    t = $signed(v << CoordShift);
    return 64'(t >>> CoordShift);
  endfunction

endpackage

// ===== rtl/vtgd_ifs.sv =====
// Valid/ready channel interfaces for the byte input and the result output.
// Depends on nothing but the standard logic types.
interface vtgd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] geometry_byte;
  logic       last_byte;

  modport source (output valid, output geometry_byte, output last_byte, input ready);
  modport sink   (input valid, input geometry_byte, input last_byte, output ready);
endinterface

interface vtgd_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic signed [63:0] point_x;
  logic signed [63:0] point_y;
  logic [1:0]         error_code;
  logic               end_of_geometry;

  modport source (output valid, output kind, output point_x, output point_y,
                  output error_code, output end_of_geometry, input ready);
  modport sink   (input valid, input kind, input point_x, input point_y,
                  input error_code, input end_of_geometry, output ready);
endinterface

// ===== rtl/vector_tile_geometry_decoder.sv =====
// A byte that ends a word passes through the queue register and then the back end's
// output register, when no earlier word waits in the queue and the output is free.
// Throughput: one byte per cycle while the queue is not full (in_bus.ready is low then).
// The two-entry queue lets the front end keep taking bytes while a result waits.
// Reset is synchronous and active low; it clears the varint, parser, cursors,
// queue and output valid at once, with no clearing pass.
module vector_tile_geometry_decoder (
  input  logic        clk,
  input  logic        rst_n,
  vtgd_in_if.sink     in_bus,
  vtgd_out_if.source  out_bus
);

`include "vector_tile_geometry_decoder_defines.svh"

  logic               push, pop;
  vtgd_pkg::tok_t     push_tok, head_tok;
  vtgd_pkg::q_stat_t  q_stat;

  vtgd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .q_stat   (q_stat),
    .push     (push),
    .push_tok (push_tok)
  );

  vtgd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tok (push_tok),
    .pop      (pop),
    .head_tok (head_tok),
    .q_stat   (q_stat)
  );

  vtgd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_tok (head_tok),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_bus  (out_bus)
  );

  `VTGD_ASSERT_NOW(a_err_has_code, clk, rst_n, out_bus.valid && out_bus.kind == vtgd_pkg::KIND_ERROR, out_bus.error_code != vtgd_pkg::ERR_NONE)
  `VTGD_ASSERT_NOW(a_ok_no_code, clk, rst_n, out_bus.valid && out_bus.kind != vtgd_pkg::KIND_ERROR, out_bus.error_code == vtgd_pkg::ERR_NONE)
  `VTGD_ASSERT_NOW(a_queue_sane, clk, rst_n, 1'b1, !(q_stat.full && q_stat.empty))
  `VTGD_ASSERT_NEXT(a_push_fills, clk, rst_n, push && q_stat.empty && !pop, !q_stat.empty)

endmodule

// ===== rtl/vtgd_front.sv =====
// Front end: assembles base-128 varints from the byte stream and pushes one word per
// finished or oversized varint or last byte into the queue. Depends on vtgd_pkg.
module vtgd_front (
  input  logic               clk,
  input  logic               rst_n,
  vtgd_in_if.sink            in_bus,
  input  vtgd_pkg::q_stat_t  q_stat,
  output logic               push,
  output vtgd_pkg::tok_t     push_tok
);

  logic [63:0] acc_r, acc_nxt;
  logic [6:0]  shift_r, shift_nxt;
  logic        skip_r, skip_nxt;
  logic        take;
  logic [63:0] acc_or;

  assign in_bus.ready = !q_stat.full;
  assign take = in_bus.valid && in_bus.ready;
  assign acc_or = acc_r | (64'(in_bus.geometry_byte[6:0]) << shift_r);

  always_comb begin
    acc_nxt        = acc_r;
    shift_nxt      = shift_r;
    skip_nxt       = skip_r;
    push           = 1'b0;
    push_tok.kind  = vtgd_pkg::TOK_WORD;
    push_tok.value = acc_or;
    push_tok.last  = in_bus.last_byte;
    if (take) begin
      if (skip_r) begin
        // After an oversized varint only the last byte matters.
        if (in_bus.last_byte) begin
          push          = 1'b1;
          push_tok.kind = vtgd_pkg::TOK_LASTONLY;
          skip_nxt      = 1'b0;
          acc_nxt       = '0;
          shift_nxt     = '0;
        end
      end else if (shift_r > vtgd_pkg::MAX_SHIFT) begin
        push          = 1'b1;
        push_tok.kind = vtgd_pkg::TOK_OVERSIZE;
        acc_nxt       = '0;
        shift_nxt     = '0;
        skip_nxt      = !in_bus.last_byte;
      end else if (in_bus.geometry_byte[7]) begin
        if (in_bus.last_byte) begin
          push          = 1'b1;
          push_tok.kind = vtgd_pkg::TOK_TRUNC;
          acc_nxt       = '0;
          shift_nxt     = '0;
        end else begin
          acc_nxt   = acc_or;
          shift_nxt = shift_r + vtgd_pkg::SHIFT_STEP;
        end
      end else begin
        push      = 1'b1;
        acc_nxt   = '0;
        shift_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      shift_r <= '0;
      skip_r  <= 1'b0;
    end else begin
      acc_r   <= acc_nxt;
      shift_r <= shift_nxt;
      skip_r  <= skip_nxt;
    end
  end

endmodule

// ===== rtl/vtgd_queue.sv =====
// Short register queue between the front end and the back end.
// Depends on vtgd_pkg for the word type and depth.
module vtgd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  vtgd_pkg::tok_t     push_tok,
  input  logic               pop,
  output vtgd_pkg::tok_t     head_tok,
  output vtgd_pkg::q_stat_t  q_stat
);

  vtgd_pkg::tok_t                 mem_r [vtgd_pkg::QDEPTH];
  logic [vtgd_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [vtgd_pkg::QCNT_W-1:0]   count_r, count_nxt;
  logic                          do_push, do_pop;

  assign q_stat.full  = (count_r == vtgd_pkg::QCNT_W'(vtgd_pkg::QDEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push  = push && !q_stat.full;
  assign do_pop   = pop && !q_stat.empty;
  assign head_tok = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/vtgd_back.sv =====
// Back end: interprets command words and parameters, moves the cursors and
// drives the registered result channel. Depends on vtgd_pkg and vtgd_ifs.
module vtgd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  vtgd_pkg::tok_t     head_tok,
  input  vtgd_pkg::q_stat_t  q_stat,
  output logic               pop,
  vtgd_out_if.source         out_bus
);

  vtgd_pkg::phase_t phase_r, phase_nxt;
  logic             is_move_r, is_move_nxt;
  logic [60:0]      repeats_r, repeats_nxt;
  logic [63:0]      cursor_x_r, cursor_x_nxt;
  logic [63:0]      cursor_y_r, cursor_y_nxt;
  logic             part_open_r, part_open_nxt;
  logic             err_latched_r, err_latched_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         out_kind_r;
  logic signed [63:0] out_x_r, out_y_r;
  logic [1:0]         out_code_r;
  logic               out_end_r;

  logic               emit, have, clear;
  vtgd_pkg::kind_t    kind;
  vtgd_pkg::err_t     err;
  logic [63:0]        px, py, sum, wrapped;
  logic [2:0]         cmd;
  logic [60:0]        cnt, rep_dec;

  assign pop     = !q_stat.empty && (!out_valid_r || out_bus.ready);
  assign cmd     = head_tok.value[2:0];
  assign cnt     = head_tok.value[63:3];
  assign rep_dec = repeats_r - 1'b1;
  // One adder serves both cursors; the phase picks which one moves.
  assign sum     = ((phase_r == vtgd_pkg::PH_Y) ? cursor_y_r : cursor_x_r)
                   + vtgd_pkg::unzigzag(head_tok.value);
  assign wrapped = vtgd_pkg::coord_wrap(sum);

  always_comb begin
    phase_nxt       = phase_r;
    is_move_nxt     = is_move_r;
    repeats_nxt     = repeats_r;
    cursor_x_nxt    = cursor_x_r;
    cursor_y_nxt    = cursor_y_r;
    part_open_nxt   = part_open_r;
    err_latched_nxt = err_latched_r;
    emit            = 1'b0;
    have            = 1'b0;
    clear           = 1'b0;
    kind            = vtgd_pkg::KIND_END;
    err             = vtgd_pkg::ERR_NONE;
    px              = '0;
    py              = '0;

    if (pop) begin
      if (err_latched_r) begin
        if (head_tok.last) begin
          clear = 1'b1;
          emit  = 1'b1;
        end
      end else begin
        unique case (head_tok.kind)
          vtgd_pkg::TOK_OVERSIZE: err = vtgd_pkg::ERR_OVERSIZE;
          vtgd_pkg::TOK_TRUNC:    err = vtgd_pkg::ERR_TRUNC;
          vtgd_pkg::TOK_LASTONLY: have = 1'b0;
          vtgd_pkg::TOK_WORD: begin
            unique case (phase_r)
              vtgd_pkg::PH_CMD: begin
                if (cmd == vtgd_pkg::CMD_MOVE || cmd == vtgd_pkg::CMD_LINE) begin
                  // A zero repeat count leaves everything as it was.
                  if (cnt != '0) begin
                    is_move_nxt = (cmd == vtgd_pkg::CMD_MOVE);
                    repeats_nxt = cnt;
                    phase_nxt   = vtgd_pkg::PH_X;
                  end
                end else if (cmd == vtgd_pkg::CMD_CLOSE) begin
                  if (part_open_r) begin
                    part_open_nxt = 1'b0;
                    have          = 1'b1;
                    kind          = vtgd_pkg::KIND_CLOSE;
                  end
                end else begin
                  err = vtgd_pkg::ERR_UNKNOWN;
                end
              end
              vtgd_pkg::PH_X: begin
                cursor_x_nxt = wrapped;
                phase_nxt    = vtgd_pkg::PH_Y;
              end
              vtgd_pkg::PH_Y: begin
                cursor_y_nxt  = wrapped;
                kind          = (is_move_r || !part_open_r) ? vtgd_pkg::KIND_START
                                                           : vtgd_pkg::KIND_EXTEND;
                part_open_nxt = 1'b1;
                have          = 1'b1;
                px            = cursor_x_r;
                py            = wrapped;
                repeats_nxt   = rep_dec;
                phase_nxt     = (rep_dec == '0) ? vtgd_pkg::PH_CMD : vtgd_pkg::PH_X;
              end
              default: phase_nxt = vtgd_pkg::PH_CMD;
            endcase
            // A stream that stops while parameters are still owed is truncated.
            if (head_tok.last && err == vtgd_pkg::ERR_NONE && phase_nxt != vtgd_pkg::PH_CMD) begin
              err = vtgd_pkg::ERR_TRUNC;
            end
          end
        endcase

        if (err != vtgd_pkg::ERR_NONE) begin
          emit = 1'b1;
          kind = vtgd_pkg::KIND_ERROR;
          px   = '0;
          py   = '0;
          if (head_tok.last) begin
            clear = 1'b1;
          end else begin
            err_latched_nxt = 1'b1;
          end
        end else if (head_tok.last) begin
          clear = 1'b1;
          emit  = 1'b1;
        end else if (have) begin
          emit = 1'b1;
        end
      end
    end

    if (clear) begin
      phase_nxt       = vtgd_pkg::PH_CMD;
      is_move_nxt     = 1'b0;
      repeats_nxt     = '0;
      cursor_x_nxt    = '0;
      cursor_y_nxt    = '0;
      part_open_nxt   = 1'b0;
      err_latched_nxt = 1'b0;
    end

    if (pop && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= vtgd_pkg::PH_CMD;
      is_move_r     <= 1'b0;
      repeats_r     <= '0;
      cursor_x_r    <= '0;
      cursor_y_r    <= '0;
      part_open_r   <= 1'b0;
      err_latched_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      is_move_r     <= is_move_nxt;
      repeats_r     <= repeats_nxt;
      cursor_x_r    <= cursor_x_nxt;
      cursor_y_r    <= cursor_y_nxt;
      part_open_r   <= part_open_nxt;
      err_latched_r <= err_latched_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_kind_r <= kind;
      out_x_r    <= $signed(px);
      out_y_r    <= $signed(py);
      out_code_r <= err;
      out_end_r  <= head_tok.last;
    end
  end

  assign out_bus.valid           = out_valid_r;
  assign out_bus.kind            = out_kind_r;
  assign out_bus.point_x         = out_x_r;
  assign out_bus.point_y         = out_y_r;
  assign out_bus.error_code      = out_code_r;
  assign out_bus.end_of_geometry = out_end_r;

endmodule
